// File: rtl/core/rrss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants of the round-robin slice scheduler: item codes,
// field widths and the task-entry and memory-write structures.
// ----------------------------------------------------------------------------
package rrss_pkg;

    localparam int TASK_DEPTH_DEF = 16;
    localparam int SLICE_W        = 32;
    localparam int TICK_W         = 64;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_ADD  = 1'b1
    } t_req_type;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic               vld;
        t_req_type          req_type;
        logic [SLICE_W-1:0] slice;
    } t_item;

    typedef struct packed {
        logic [SLICE_W-1:0] slice;
        logic [SLICE_W-1:0] ticks;
    } t_task_entry;

    typedef struct packed {
        logic        en;
        t_task_entry data;
    } t_mem_wr;

endpackage
`default_nettype wire

// File: rtl/core/rrss_task_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_task_mem
// Task table memory: one write port and one registered read port with
// write-through forwarding, used to prefetch the next task's entry.
// ----------------------------------------------------------------------------
module rrss_task_mem #(
    parameter int DEPTH  = rrss_pkg::TASK_DEPTH_DEF,
    parameter int ADDR_W = 4
) (
    input  wire                       i_clk,
    input  rrss_pkg::t_mem_wr         i_wr,
    input  wire  [ADDR_W-1:0]         i_wr_addr,
    input  wire  [ADDR_W-1:0]         i_rd_addr,
    output rrss_pkg::t_task_entry     o_rd
);
    import rrss_pkg::*;

    t_task_entry r_mem [DEPTH];
    t_task_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        // Forward a same-cycle write so the prefetch never sees stale data.
        if (i_wr.en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr.data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule
`default_nettype wire

// File: rtl/core/rrss_sched_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_sched_ctrl
// Scheduler state and step logic: task count, current slot, slice progress,
// cached current entry, global tick count and the result registers.
// ----------------------------------------------------------------------------
module rrss_sched_ctrl #(
    parameter int TASK_DEPTH = rrss_pkg::TASK_DEPTH_DEF,
    parameter int SLOT_W     = 4,
    parameter int ID_W       = 5
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  rrss_pkg::t_item               i_item,
    input  rrss_pkg::t_task_entry         i_nxt,
    output rrss_pkg::t_mem_wr             o_wr,
    output logic [SLOT_W-1:0]             o_wr_addr,
    output logic [SLOT_W-1:0]             o_rd_addr,
    output logic                          o_done,
    output logic                          o_reg_status,
    output logic [ID_W-1:0]               o_assigned_id,
    output logic [ID_W-1:0]               o_current_task_id,
    output logic [ID_W-1:0]               o_tasks_in_table,
    output logic [rrss_pkg::TICK_W-1:0]   o_tick_total,
    output logic [rrss_pkg::SLICE_W-1:0]  o_charged_ticks
);
    import rrss_pkg::*;

    logic [ID_W-1:0]    r_cnt,        n_cnt;
    logic [SLOT_W-1:0]  r_slot,       n_slot;
    logic [SLICE_W-1:0] r_prog,       n_prog;
    logic [TICK_W-1:0]  r_total,      n_total;
    logic [SLICE_W-1:0] r_cur_slice,  n_cur_slice;
    logic [SLICE_W-1:0] r_cur_ticks,  n_cur_ticks;

    logic               r_done;
    logic               r_status,     n_status;
    logic [ID_W-1:0]    r_id,         n_id;
    logic [ID_W-1:0]    r_cur_id;
    logic [ID_W-1:0]    r_tasks;
    logic [TICK_W-1:0]  r_tick_total;
    logic [SLICE_W-1:0] r_charged;

    logic               full;
    logic [SLICE_W-1:0] slice_eff;
    logic [SLICE_W-1:0] ticks_inc;
    logic [SLICE_W:0]   prog_inc;

    function automatic logic [SLOT_W-1:0] f_next_slot(
        input logic [SLOT_W-1:0] slot,
        input logic [ID_W-1:0]   cnt
    );
        logic [ID_W:0] s1;
        s1 = (ID_W+1)'(slot) + (ID_W+1)'(1);
        return (s1 >= (ID_W+1)'(cnt)) ? '0 : s1[SLOT_W-1:0];
    endfunction

    assign full      = (r_cnt == ID_W'(TASK_DEPTH));
    assign slice_eff = (i_item.slice == '0) ? SLICE_W'(1) : i_item.slice;
    assign ticks_inc = r_cur_ticks + SLICE_W'(1);
    assign prog_inc  = (SLICE_W+1)'(r_prog) + (SLICE_W+1)'(1);

    always_comb begin
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_prog      = r_prog;
        n_total     = r_total;
        n_cur_slice = r_cur_slice;
        n_cur_ticks = r_cur_ticks;
        n_status    = ST_OK;
        n_id        = '0;
        o_wr        = '0;
        o_wr_addr   = r_slot;

        if (i_item.vld) begin
            unique case (i_item.req_type)
                REQ_ADD: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cnt            = r_cnt + ID_W'(1);
                        n_id             = r_cnt + ID_W'(1);
                        o_wr.en          = 1'b1;
                        o_wr.data.slice  = slice_eff;
                        o_wr.data.ticks  = '0;
                        o_wr_addr        = r_cnt[SLOT_W-1:0];
                        if (r_cnt == '0) begin
                            n_cur_slice = slice_eff;
                            n_cur_ticks = '0;
                        end
                    end
                end
                REQ_TICK: begin
                    n_total = r_total + TICK_W'(1);
                    if (r_cnt != '0) begin
                        n_cur_ticks = ticks_inc;
                        if (prog_inc >= (SLICE_W+1)'(r_cur_slice)) begin
                            // Slice used up: save this task and switch over.
                            n_prog          = '0;
                            o_wr.en         = 1'b1;
                            o_wr.data.slice = r_cur_slice;
                            o_wr.data.ticks = ticks_inc;
                            o_wr_addr       = r_slot;
                            n_slot          = f_next_slot(r_slot, r_cnt);
                            if (r_cnt != ID_W'(1)) begin
                                n_cur_slice = i_nxt.slice;
                                n_cur_ticks = i_nxt.ticks;
                            end
                        end else begin
                            n_prog = prog_inc[SLICE_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Prefetch address follows the state as it will be after this edge.
    assign o_rd_addr = f_next_slot(n_slot, n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_slot  <= '0;
            r_prog  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_prog  <= n_prog;
            r_total <= n_total;
            r_done  <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_slice <= n_cur_slice;
        r_cur_ticks <= n_cur_ticks;
        if (i_item.vld) begin
            r_status     <= n_status;
            r_id         <= n_id;
            r_cur_id     <= (n_cnt != '0) ? (ID_W'(n_slot) + ID_W'(1)) : '0;
            r_tasks      <= n_cnt;
            r_tick_total <= n_total;
            r_charged    <= (n_cnt != '0) ? n_cur_ticks : '0;
        end
    end

    assign o_done            = r_done;
    assign o_reg_status      = r_status;
    assign o_assigned_id     = r_id;
    assign o_current_task_id = r_cur_id;
    assign o_tasks_in_table  = r_tasks;
    assign o_tick_total      = r_tick_total;
    assign o_charged_ticks   = r_charged;

endmodule
`default_nettype wire

// File: rtl/core/round_robin_slice_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler over a fixed task table, driven by tick
// and task-register items, reporting scheduling statistics for every item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------
//  item in   start high, busy low   i_req_type, i_slice_ticks
//  result    o_done for one cycle   o_reg_status, o_assigned_id,
//                                   o_current_task_id, o_tasks_in_table,
//                                   o_tick_total, o_charged_ticks
//
// One item is accepted in every cycle; busy stays low. The result of an item
// passes the input register, then the step logic feeding the result registers;
// no other register lies on its path. The task memory's registered read port
// prefetches the next task's entry, so a slot switch adds no register to it.
// Reset is synchronous and active low; it empties the task table and clears
// the tick count and slice progress, and takes effect at once with no pass.
// The receiver cannot stall, so every result is shown exactly once, in the
// cycle marked by o_done.
//
module round_robin_slice_scheduler #(
    parameter int TASK_DEPTH = rrss_pkg::TASK_DEPTH_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire                                     i_req_type,
    input  wire  [rrss_pkg::SLICE_W-1:0]            i_slice_ticks,
    output logic                                    o_done,
    output logic                                    o_reg_status,
    output logic [$clog2(TASK_DEPTH+1)-1:0]         o_assigned_id,
    output logic [$clog2(TASK_DEPTH+1)-1:0]         o_current_task_id,
    output logic [$clog2(TASK_DEPTH+1)-1:0]         o_tasks_in_table,
    output logic [rrss_pkg::TICK_W-1:0]             o_tick_total,
    output logic [rrss_pkg::SLICE_W-1:0]            o_charged_ticks
);
    import rrss_pkg::*;

    localparam int ID_W   = $clog2(TASK_DEPTH + 1);
    localparam int SLOT_W = (TASK_DEPTH > 1) ? $clog2(TASK_DEPTH) : 1;

    // Input register: holds the accepted item for the step logic.
    t_item       r_item;
    t_task_entry nxt_entry;
    t_mem_wr     mem_wr;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic [SLOT_W-1:0] mem_rd_addr;

    // The step logic finishes an item every cycle, so no item is ever refused.
    assign busy = 1'b0;

    // Only the valid bit is reset; the payload is captured on every accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item.vld <= start && !busy;
        end
        if (start && !busy) begin
            r_item.req_type <= t_req_type'(i_req_type);
            r_item.slice    <= i_slice_ticks;
        end
    end

    rrss_sched_ctrl #(
        .TASK_DEPTH (TASK_DEPTH),
        .SLOT_W     (SLOT_W),
        .ID_W       (ID_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (r_item),
        .i_nxt             (nxt_entry),
        .o_wr              (mem_wr),
        .o_wr_addr         (mem_wr_addr),
        .o_rd_addr         (mem_rd_addr),
        .o_done            (o_done),
        .o_reg_status      (o_reg_status),
        .o_assigned_id     (o_assigned_id),
        .o_current_task_id (o_current_task_id),
        .o_tasks_in_table  (o_tasks_in_table),
        .o_tick_total      (o_tick_total),
        .o_charged_ticks   (o_charged_ticks)
    );

    // Task table: slice length and ticks seen per slot. The current task's
    // entry lives in the controller; the memory copy is saved on a switch.
    rrss_task_mem #(
        .DEPTH  (TASK_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_wr_addr (mem_wr_addr),
        .i_rd_addr (mem_rd_addr),
        .o_rd      (nxt_entry)
    );

endmodule
`default_nettype wire

// File: rtl/core/rrss_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_checker
// Port-level checks of the round-robin slice scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrss_checker #(
    parameter int TASK_DEPTH = rrss_pkg::TASK_DEPTH_DEF
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  start,
    input wire                                  busy,
    input wire                                  i_req_type,
    input wire [rrss_pkg::SLICE_W-1:0]          i_slice_ticks,
    input wire                                  o_done,
    input wire                                  o_reg_status,
    input wire [$clog2(TASK_DEPTH+1)-1:0]       o_assigned_id,
    input wire [$clog2(TASK_DEPTH+1)-1:0]       o_current_task_id,
    input wire [$clog2(TASK_DEPTH+1)-1:0]       o_tasks_in_table,
    input wire [rrss_pkg::TICK_W-1:0]           o_tick_total,
    input wire [rrss_pkg::SLICE_W-1:0]          o_charged_ticks
);
    import rrss_pkg::*;

    // Every accepted item yields its result once it has passed the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("accepted item produced no result");

    // No result without a matching item accepted ahead of it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a matching item");

    // A refused registration assigns no id.
    a_full_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_reg_status == ST_FULL)) |-> (o_assigned_id == '0))
        else $error("full status with a nonzero assigned id");

    // With an empty table there is no current task and nothing charged.
    a_empty_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_tasks_in_table == '0)) |->
            ((o_current_task_id == '0) && (o_charged_ticks == '0)))
        else $error("current task reported with an empty table");

    // The current task is always one of the registered tasks.
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_current_task_id <= o_tasks_in_table))
        else $error("current task id beyond the task count");

endmodule

bind round_robin_slice_scheduler rrss_checker #(.TASK_DEPTH(TASK_DEPTH)) u_rrss_checker (.*);
`default_nettype wire
